>>> hw/rtl/bqd_pkg.sv
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared codes, field widths and defaults for the bounded queue with delete.
// ----------------------------------------------------------------------------
package bqd_pkg;

   // defaults for the top-level parameters
   localparam int DEPTH_DEFAULT      = 16;
   localparam int ITEM_WIDTH_DEFAULT = 32;

   // field widths on the streams
   localparam int REQ_TYPE_W    = 3;
   localparam int ITEM_W        = 32;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_TOTAL_W = 5;

   localparam int REQ_FIELDS_W  = REQ_TYPE_W + ITEM_W;
   localparam int REQ_TDATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W  = STATUS_W + ITEM_W + ENTRY_TOTAL_W;
   localparam int RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_TDATA_W - RSP_FIELDS_W;

   typedef logic [REQ_TYPE_W-1:0] req_code_type;
   typedef logic [STATUS_W-1:0]   status_type;

   // request codes
   localparam req_code_type REQ_APPEND = 3'd0;
   localparam req_code_type REQ_PUSH   = 3'd1;
   localparam req_code_type REQ_POP    = 3'd2;
   localparam req_code_type REQ_DELETE = 3'd3;
   localparam req_code_type REQ_WALK   = 3'd4;

   // status codes
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_FULL      = 2'd1;
   localparam status_type ST_EMPTY     = 2'd2;
   localparam status_type ST_NOT_FOUND = 2'd3;

endpackage

>>> hw/rtl/bqd_ram.sv
// ----------------------------------------------------------------------------
// bqd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bqd_ram #(
   parameter int WIDTH = bqd_pkg::ITEM_WIDTH_DEFAULT,
   parameter int DEPTH = bqd_pkg::DEPTH_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bounded_queue_with_delete_unit.sv
// ----------------------------------------------------------------------------
// bounded_queue_with_delete_unit
// Bounded double-ended queue in a circular RAM with append, push, pop,
// delete-first-match (gap closed in order) and walk of all entries.
// ----------------------------------------------------------------------------
// Sequencing: append, push and rejected requests go from acceptance to EMIT;
//   pop first waits in POP_WAIT for the head entry. Delete runs SCAN_RD and
//   SCAN_CMP per entry scanned, then SHIFT_RD and SHIFT_WR per entry moved to
//   close the gap, then EMIT; walk runs WALK_RD, WALK_DATA and EMIT per entry.
//   The single RAM read port with registered data sets these steps.
// Throughput: one request at a time; req_tready is high only between requests.
// Reset clears head, count and the sequencer; the store is not cleared.
// ----------------------------------------------------------------------------
module bounded_queue_with_delete_unit #(
   parameter int DEPTH      = bqd_pkg::DEPTH_DEFAULT,
   parameter int ITEM_WIDTH = bqd_pkg::ITEM_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [2:0] req_type, [34:3] item_in, upper bits zero
   input  logic [bqd_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [1:0] status, [33:2] item_out, [38:34] entry_total, upper bits zero
   output logic [bqd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_POP_WAIT  = 4'd1;
   localparam logic [3:0] S_SCAN_RD   = 4'd2;
   localparam logic [3:0] S_SCAN_CMP  = 4'd3;
   localparam logic [3:0] S_SHIFT_RD  = 4'd4;
   localparam logic [3:0] S_SHIFT_WR  = 4'd5;
   localparam logic [3:0] S_WALK_RD   = 4'd6;
   localparam logic [3:0] S_WALK_DATA = 4'd7;
   localparam logic [3:0] S_EMIT      = 4'd8;

   logic [3:0]                    state_ff, state_in;
   logic [AW-1:0]                 head_ff, head_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic [ITEM_WIDTH-1:0]         key_ff, key_in;
   bqd_pkg::status_type           pend_status_ff, pend_status_in;
   logic [bqd_pkg::ITEM_W-1:0]    pend_item_ff, pend_item_in;
   logic                          pend_last_ff, pend_last_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   bqd_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [bqd_pkg::ITEM_W-1:0]    rsp_item_ff, rsp_item_in;
   logic [bqd_pkg::ENTRY_TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic                          rsp_last_ff, rsp_last_in;

   bqd_pkg::req_code_type         req_type;
   logic [ITEM_WIDTH-1:0]         req_item;
   logic                          req_accept;
   logic                          out_free;
   logic                          count_full, count_zero;
   logic [CW-1:0]                 idx_plus1;
   logic [CW:0]                   idx_plus2;
   logic [AW-1:0]                 head_dec;

   // shared slot adder: (head + offset) mod DEPTH
   logic [CW-1:0]                 slot_off;
   logic [SW-1:0]                 slot_sum;
   logic [AW-1:0]                 slot_addr;

   logic                          ram_we, ram_re;
   logic [AW-1:0]                 ram_waddr, ram_raddr;
   logic [ITEM_WIDTH-1:0]         ram_wdata, ram_rdata;

   assign req_type   = req_tdata[bqd_pkg::REQ_TYPE_W-1:0];
   assign req_item   = ITEM_WIDTH'(req_tdata[bqd_pkg::REQ_TYPE_W +: bqd_pkg::ITEM_W]);
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign count_full = (count_ff == CW'(DEPTH));
   assign count_zero = (count_ff == '0);
   assign idx_plus1  = idx_ff + CW'(1);
   assign idx_plus2  = {1'b0, idx_ff} + (CW+1)'(2);
   assign head_dec   = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);

   always_comb begin
      case (state_ff)
         S_IDLE:     slot_off = count_ff;
         S_POP_WAIT: slot_off = CW'(1);
         S_SHIFT_RD: slot_off = idx_plus1;
         default:    slot_off = idx_ff;
      endcase
   end

   assign slot_sum  = SW'(head_ff) + SW'(slot_off);
   assign slot_addr = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH)) : AW'(slot_sum);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      key_in         = key_ff;
      pend_status_in = pend_status_ff;
      pend_item_in   = pend_item_ff;
      pend_last_in   = pend_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_item_in    = rsp_item_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_last_in    = rsp_last_ff;
      ram_we         = 1'b0;
      ram_waddr      = slot_addr;
      ram_wdata      = ram_rdata;
      ram_re         = 1'b0;
      ram_raddr      = slot_addr;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               pend_item_in   = '0;
               pend_last_in   = 1'b1;
               pend_status_in = bqd_pkg::ST_EMPTY;
               key_in         = req_item;
               idx_in         = '0;
               state_in       = S_EMIT;
               case (req_type)
                  bqd_pkg::REQ_APPEND: begin
                     if (count_full) begin
                        pend_status_in = bqd_pkg::ST_FULL;
                     end else begin
                        ram_we         = 1'b1;
                        ram_wdata      = req_item;
                        count_in       = count_ff + CW'(1);
                        pend_status_in = bqd_pkg::ST_OK;
                     end
                  end
                  bqd_pkg::REQ_PUSH: begin
                     if (count_full) begin
                        pend_status_in = bqd_pkg::ST_FULL;
                     end else begin
                        ram_we         = 1'b1;
                        ram_waddr      = head_dec;
                        ram_wdata      = req_item;
                        head_in        = head_dec;
                        count_in       = count_ff + CW'(1);
                        pend_status_in = bqd_pkg::ST_OK;
                     end
                  end
                  bqd_pkg::REQ_POP: begin
                     if (!count_zero) begin
                        ram_re    = 1'b1;
                        ram_raddr = head_ff;
                        state_in  = S_POP_WAIT;
                     end
                  end
                  bqd_pkg::REQ_DELETE: begin
                     if (!count_zero && (req_item != '0)) begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  bqd_pkg::REQ_WALK: begin
                     if (!count_zero) begin
                        state_in = S_WALK_RD;
                     end
                  end
                  default: begin
                     pend_status_in = bqd_pkg::ST_EMPTY;
                  end
               endcase
            end
         end
         S_POP_WAIT: begin
            pend_item_in   = bqd_pkg::ITEM_W'(ram_rdata);
            pend_status_in = bqd_pkg::ST_OK;
            count_in       = count_ff - CW'(1);
            // popping the only entry parks the head at zero
            head_in        = (count_ff == CW'(1)) ? '0 : slot_addr;
            state_in       = S_EMIT;
         end
         S_SCAN_RD: begin
            ram_re   = 1'b1;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (ram_rdata == key_ff) begin
               if (idx_plus1 == count_ff) begin
                  // match at the tail: nothing to move
                  count_in       = count_ff - CW'(1);
                  head_in        = (count_ff == CW'(1)) ? '0 : head_ff;
                  pend_status_in = bqd_pkg::ST_OK;
                  state_in       = S_EMIT;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end else if (idx_plus1 == count_ff) begin
               pend_status_in = bqd_pkg::ST_NOT_FOUND;
               state_in       = S_EMIT;
            end else begin
               idx_in   = idx_plus1;
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            ram_re   = 1'b1;
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            // move the next entry one place toward the head
            ram_we = 1'b1;
            idx_in = idx_plus1;
            if (idx_plus2 < {1'b0, count_ff}) begin
               state_in = S_SHIFT_RD;
            end else begin
               count_in       = count_ff - CW'(1);
               pend_status_in = bqd_pkg::ST_OK;
               state_in       = S_EMIT;
            end
         end
         S_WALK_RD: begin
            ram_re   = 1'b1;
            state_in = S_WALK_DATA;
         end
         S_WALK_DATA: begin
            pend_item_in   = bqd_pkg::ITEM_W'(ram_rdata);
            pend_status_in = bqd_pkg::ST_OK;
            pend_last_in   = (idx_plus1 == count_ff);
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_item_in   = pend_item_ff;
               rsp_total_in  = bqd_pkg::ENTRY_TOTAL_W'(count_ff);
               rsp_last_in   = pend_last_ff;
               if (pend_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_plus1;
                  state_in = S_WALK_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      key_ff         <= key_in;
      pend_status_ff <= pend_status_in;
      pend_item_ff   <= pend_item_in;
      pend_last_ff   <= pend_last_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_item_ff    <= rsp_item_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_last_ff    <= rsp_last_in;
   end

   bqd_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{bqd_pkg::RSP_PAD_W{1'b0}}, rsp_total_ff, rsp_item_ff, rsp_status_ff};

   // an empty queue always has its head parked at zero
   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0))
      else $error("empty queue with nonzero head");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free && pend_status_ff == bqd_pkg::ST_FULL)
      |-> (count_ff == CW'(DEPTH)))
      else $error("full status with room left");

   a_nonlast_is_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !pend_last_ff) |-> (pend_status_ff == bqd_pkg::ST_OK))
      else $error("non-final word with error status");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_IDLE || state_ff == S_SHIFT_WR))
      else $error("store written outside of add or shift");

endmodule
